// File: rtl/triangle_depth_rasterizer_unit_assert.svh
// assertion macros used by the rasterizer checker
`ifndef TRIANGLE_DEPTH_RASTERIZER_UNIT_ASSERT_SVH
`define TRIANGLE_DEPTH_RASTERIZER_UNIT_ASSERT_SVH

// same-cycle implication, reset masks the check
`define TDR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define TDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tdr_pkg.sv
// shared types, codes and helpers of the triangle depth rasterizer
`timescale 1ns / 1ps
`default_nettype none
package tdr_pkg;

	localparam int FRAME_WIDTH_DEF  = 256;
	localparam int FRAME_HEIGHT_DEF = 256;

	// item modes carried on the input tuser
	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_STEP  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// result status carried on the output tuser
	localparam logic [1:0] STAT_WRITTEN = 2'd0;
	localparam logic [1:0] STAT_OUTSIDE = 2'd1;
	localparam logic [1:0] STAT_REJECT  = 2'd2;
	localparam logic [1:0] STAT_IDLE    = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_VIEW_WIDTH  = 2'd0;
	localparam logic [1:0] REG_VIEW_HEIGHT = 2'd1;
	localparam logic [1:0] REG_VIEW_X      = 2'd2;
	localparam logic [1:0] REG_VIEW_Y      = 2'd3;

	localparam logic [31:0] DEPTH_CLEAR = 32'hFC18_0000;
	localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
	localparam int DIV_W  = 64;
	localparam int SCR_W  = 28;
	localparam int EDGE_W = 24;

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_CHK, ST_VDIV, ST_VWAIT, ST_SMUL, ST_SADD, ST_BOX,
		ST_AR1, ST_AR2, ST_AR3, ST_E1, ST_E2, ST_E3, ST_E4, ST_E5,
		ST_WAW, ST_WBS, ST_WBW, ST_WC, ST_Z0, ST_Z1, ST_Z2, ST_Z3, ST_Z4
	} tdr_state_t;

	// saturate a signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			return -32'sh8000_0000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage
`default_nettype wire

// File: rtl/tdr_div.sv
// iterative signed divider, truncating quotient, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module tdr_div #(
	parameter int W = tdr_pkg::DIV_W
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic signed [W-1:0] dividend,
	input  wire logic signed [W-1:0] divisor,
	output logic                     done,
	output logic signed [W-1:0]      quotient
);
	localparam int CNT_W = $clog2(W);

	logic             busy_q, done_q, neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     num_q, den_q, quo_q;
	logic [W:0]       rem_q, rem_sh;
	logic             fits;

	// shift in the next dividend bit and trial subtract
	assign rem_sh   = {rem_q[W-1:0], num_q[W-1]};
	assign fits     = rem_sh >= {1'b0, den_q};
	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend[W-1] ? W'(-dividend) : dividend;
			den_q <= divisor[W-1] ? W'(-divisor) : divisor;
			neg_q <= dividend[W-1] ^ divisor[W-1];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[W-2:0], fits};
			num_q <= {num_q[W-2:0], 1'b0};
		end
	end
endmodule
`default_nettype wire

// File: rtl/tdr_zbuf.sv
// depth store: synchronous memory with one write and one registered read
`timescale 1ns / 1ps
`default_nettype none
module tdr_zbuf #(
	parameter int DEPTH = tdr_pkg::FRAME_WIDTH_DEF * tdr_pkg::FRAME_HEIGHT_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic [AW-1:0] raddr,
	output logic [31:0]        rdata
);
	logic [31:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/triangle_depth_rasterizer_unit.sv
// top level: triangle setup, pixel scan sequencer and depth test
`timescale 1ns / 1ps
`default_nettype none
// Takes one item at a time. A vertex load on slot 0 or 1 only stores the vertex;
// a load on slot 2 also runs triangle setup when every w is positive: nine
// divisions through the shared divider plus box and area steps. A pixel step runs
// two weight divisions on the same divider and, for a pixel inside the triangle,
// the depth multiply-accumulate; a step with no triangle or on a degenerate
// triangle is answered from the idle state. A clear item, and the clearing pass
// after reset, sweeps the depth memory one entry a cycle, FRAME_WIDTH*FRAME_HEIGHT
// entries (65536 by default), during which no item is taken. A new item is taken
// only while the output register is empty or its result is being taken.
module triangle_depth_rasterizer_unit #(
	parameter int FRAME_WIDTH  = tdr_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = tdr_pkg::FRAME_HEIGHT_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// vertex_slot, clip_x, clip_y, clip_z, clip_w, zero fill
	input  wire logic [135:0] s_tdata,
	// mode
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// pixel_x, pixel_y, depth, weight_a, weight_b, weight_c
	output logic [143:0]      m_tdata,
	// status
	output logic [1:0]        m_tuser,
	// last
	output logic              m_tlast,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [9:0]   cfg_wdata
);
	localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(FRAME_WIDTH);
	localparam int RW    = $clog2(FRAME_HEIGHT);
	localparam int SW    = tdr_pkg::SCR_W;
	localparam int EW    = tdr_pkg::EDGE_W;
	localparam int DW    = tdr_pkg::DIV_W;

	tdr_pkg::tdr_state_t state_q, state_d;

	// configuration
	logic [8:0]        vw_q, vh_q;
	logic signed [9:0] vx_q, vy_q;

	// triangle state
	logic signed [31:0]   xyz_q [9];
	logic signed [31:0]   w_q [3];
	logic signed [31:0]   nz_q [3];
	logic signed [SW-1:0] scr_q [6];
	logic [CW-1:0]        bx0_q, bx1_q, sx_q;
	logic [RW-1:0]        by0_q, by1_q, sy_q;
	logic signed [48:0]   area_q, pbc_q;
	logic                 degen_q, active_q;
	logic [1:0]           vi_q, vc_q;
	logic [AW-1:0]        clr_q;

	// working registers
	logic signed [31:0]      n_q, wa_q, wb_q, wc_q;
	logic signed [41:0]      sp_q;
	logic signed [2*EW-1:0]  mp_q, ma_q;
	logic signed [63:0]      zp_q;
	logic signed [65:0]      acc_q;

	// output register
	logic         out_v_q, out_last_q;
	logic [1:0]   out_stat_q;
	logic [143:0] out_data_q;

	// divider and memory hookup
	logic                 div_start, div_done;
	logic signed [DW-1:0] div_num, div_den, div_quo;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr, pix_addr;
	logic [31:0]          mem_wdata, mem_rdata;

	// combinational helpers
	logic                 acc_in, w_bad, is_last, clr_last, wneg, emit, emit_adv;
	logic [1:0]           in_mode, in_slot;
	logic [3:0]           vidx;
	logic signed [31:0]   q_sat, wc_next, z_next;
	logic signed [43:0]   s_sum;
	logic signed [42:0]   s_half;
	logic signed [SW-1:0] s_sat;
	logic signed [19:0]   qc [6];
	logic signed [EW-1:0] px, py, ea, eb;
	logic signed [SW-1:0] xmin, xmax, ymin, ymax;
	logic [1:0]           e_stat;
	logic signed [31:0]   e_z, e_wa, e_wb, e_wc;
	logic [7:0]           e_x, e_y;
	logic                 e_last;

	function automatic logic signed [SW-1:0] min3(input logic signed [SW-1:0] a,
			input logic signed [SW-1:0] b, input logic signed [SW-1:0] c);
		logic signed [SW-1:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic logic signed [SW-1:0] max3(input logic signed [SW-1:0] a,
			input logic signed [SW-1:0] b, input logic signed [SW-1:0] c);
		logic signed [SW-1:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic logic [11:0] clamp(input logic signed [31:0] v, input int hi);
		if (v < 0) begin
			return '0;
		end else if (v > hi) begin
			return 12'(hi);
		end else begin
			return v[11:0];
		end
	endfunction

	assign in_mode  = s_tuser;
	assign in_slot  = s_tdata[1:0];
	assign acc_in   = s_tvalid && s_tready;
	assign w_bad    = (w_q[0] <= 0) || (w_q[1] <= 0) || (w_q[2] <= 0);
	assign is_last  = (sx_q == bx1_q) && (sy_q == by1_q);
	assign clr_last = clr_q == AW'(DEPTH - 1);
	assign vidx     = 4'(vi_q) * 4'd3 + 4'(vc_q);
	assign q_sat    = tdr_pkg::sat32(div_quo);
	assign pix_addr = AW'(sy_q) * AW'(FRAME_WIDTH) + AW'(sx_q);

	// screen mapping: floor((n*v + off*2^17 + v*2^16) / 2), saturated
	always_comb begin
		logic [8:0]        vsel;
		logic signed [9:0] osel;
		vsel   = (vc_q == 2'd0) ? vw_q : vh_q;
		osel   = (vc_q == 2'd0) ? vx_q : vy_q;
		s_sum  = 44'(sp_q) + (44'(osel) <<< 17) + (44'({1'b0, vsel}) <<< 16);
		s_half = 43'(s_sum >>> 1);
		if (s_half > 43'sd134217727) begin
			s_sat = SW'(134217727);
		end else if (s_half < -43'sd134217728) begin
			s_sat = -SW'(134217728);
		end else begin
			s_sat = s_half[SW-1:0];
		end
	end

	// edge coordinates in Q.8 and the shared edge multiplier operands
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			qc[k] = 20'(scr_q[k] >>> 8);
		end
		px   = $signed(EW'(sx_q) << 8);
		py   = $signed(EW'(sy_q) << 8);
		xmin = min3(scr_q[0], scr_q[2], scr_q[4]);
		xmax = max3(scr_q[0], scr_q[2], scr_q[4]);
		ymin = min3(scr_q[1], scr_q[3], scr_q[5]);
		ymax = max3(scr_q[1], scr_q[3], scr_q[5]);
		case (state_q)
			tdr_pkg::ST_AR1: begin
				ea = EW'(qc[2]) - EW'(qc[0]);
				eb = EW'(qc[5]) - EW'(qc[1]);
			end
			tdr_pkg::ST_AR2: begin
				ea = EW'(qc[4]) - EW'(qc[0]);
				eb = EW'(qc[3]) - EW'(qc[1]);
			end
			tdr_pkg::ST_E1: begin
				ea = EW'(qc[2]) - px;
				eb = EW'(qc[5]) - py;
			end
			tdr_pkg::ST_E2: begin
				ea = EW'(qc[4]) - px;
				eb = EW'(qc[3]) - py;
			end
			tdr_pkg::ST_E3: begin
				ea = EW'(qc[4]) - px;
				eb = EW'(qc[1]) - py;
			end
			default: begin
				ea = EW'(qc[0]) - px;
				eb = EW'(qc[5]) - py;
			end
		endcase
	end

	// weight c and interpolated depth
	always_comb begin
		wc_next = tdr_pkg::sat32(64'($signed(ONE_Q16_S)) - 64'(wa_q) - 64'(wb_q));
		wneg    = wa_q[31] || wb_q[31] || wc_next[31];
		z_next  = tdr_pkg::sat32($signed(64'(acc_q >>> 16)));
	end

	localparam logic signed [31:0] ONE_Q16_S = tdr_pkg::ONE_Q16;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tdr_pkg::ST_CLR: if (clr_last) state_d = tdr_pkg::ST_IDLE;
			tdr_pkg::ST_IDLE: begin
				if (acc_in) begin
					if (in_mode == tdr_pkg::MODE_LOAD && in_slot == 2'd2) begin
						state_d = tdr_pkg::ST_CHK;
					end else if (in_mode == tdr_pkg::MODE_CLEAR) begin
						state_d = tdr_pkg::ST_CLR;
					end else if (in_mode == tdr_pkg::MODE_STEP && active_q && !degen_q) begin
						state_d = tdr_pkg::ST_E1;
					end
				end
			end
			tdr_pkg::ST_CHK:  state_d = w_bad ? tdr_pkg::ST_IDLE : tdr_pkg::ST_VDIV;
			tdr_pkg::ST_VDIV: state_d = tdr_pkg::ST_VWAIT;
			tdr_pkg::ST_VWAIT: begin
				if (div_done) begin
					if (vc_q != 2'd2) begin
						state_d = tdr_pkg::ST_SMUL;
					end else if (vi_q == 2'd2) begin
						state_d = tdr_pkg::ST_BOX;
					end else begin
						state_d = tdr_pkg::ST_VDIV;
					end
				end
			end
			tdr_pkg::ST_SMUL: state_d = tdr_pkg::ST_SADD;
			tdr_pkg::ST_SADD: state_d = tdr_pkg::ST_VDIV;
			tdr_pkg::ST_BOX:  state_d = tdr_pkg::ST_AR1;
			tdr_pkg::ST_AR1:  state_d = tdr_pkg::ST_AR2;
			tdr_pkg::ST_AR2:  state_d = tdr_pkg::ST_AR3;
			tdr_pkg::ST_AR3:  state_d = tdr_pkg::ST_IDLE;
			tdr_pkg::ST_E1:   state_d = tdr_pkg::ST_E2;
			tdr_pkg::ST_E2:   state_d = tdr_pkg::ST_E3;
			tdr_pkg::ST_E3:   state_d = tdr_pkg::ST_E4;
			tdr_pkg::ST_E4:   state_d = tdr_pkg::ST_E5;
			tdr_pkg::ST_E5:   state_d = tdr_pkg::ST_WAW;
			tdr_pkg::ST_WAW:  if (div_done) state_d = tdr_pkg::ST_WBS;
			tdr_pkg::ST_WBS:  state_d = tdr_pkg::ST_WBW;
			tdr_pkg::ST_WBW:  if (div_done) state_d = tdr_pkg::ST_WC;
			tdr_pkg::ST_WC:   state_d = wneg ? tdr_pkg::ST_IDLE : tdr_pkg::ST_Z0;
			tdr_pkg::ST_Z0:   state_d = tdr_pkg::ST_Z1;
			tdr_pkg::ST_Z1:   state_d = tdr_pkg::ST_Z2;
			tdr_pkg::ST_Z2:   state_d = tdr_pkg::ST_Z3;
			tdr_pkg::ST_Z3:   state_d = tdr_pkg::ST_Z4;
			tdr_pkg::ST_Z4:   state_d = tdr_pkg::ST_IDLE;
			default:          state_d = tdr_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready  = (state_q == tdr_pkg::ST_IDLE) && (!out_v_q || m_tready);
		div_start = 1'b0;
		div_num   = '0;
		div_den   = 64'(area_q);
		mem_we    = 1'b0;
		mem_waddr = pix_addr;
		mem_wdata = z_next;
		emit      = 1'b0;
		emit_adv  = 1'b0;
		e_x       = 8'(sx_q);
		e_y       = 8'(sy_q);
		e_last    = is_last;
		e_stat    = tdr_pkg::STAT_OUTSIDE;
		e_z       = '0;
		e_wa      = wa_q;
		e_wb      = wb_q;
		e_wc      = wc_next;
		case (state_q)
			tdr_pkg::ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = tdr_pkg::DEPTH_CLEAR;
			end
			tdr_pkg::ST_IDLE: begin
				if (acc_in && in_mode == tdr_pkg::MODE_STEP) begin
					if (!active_q) begin
						emit   = 1'b1;
						e_x    = '0;
						e_y    = '0;
						e_last = 1'b1;
						e_stat = tdr_pkg::STAT_IDLE;
						e_wa   = '0;
						e_wb   = '0;
						e_wc   = '0;
					end else if (degen_q) begin
						emit     = 1'b1;
						emit_adv = 1'b1;
						e_wa     = -ONE_Q16_S;
						e_wb     = ONE_Q16_S;
						e_wc     = ONE_Q16_S;
					end
				end
			end
			tdr_pkg::ST_VDIV: begin
				div_start = 1'b1;
				div_num   = 64'(xyz_q[vidx]) <<< 16;
				div_den   = 64'(w_q[vi_q]);
			end
			tdr_pkg::ST_E5: begin
				div_start = 1'b1;
				div_num   = 64'(pbc_q) <<< 16;
			end
			tdr_pkg::ST_WBS: begin
				div_start = 1'b1;
				div_num   = 64'(pbc_q) <<< 16;
			end
			tdr_pkg::ST_WC: begin
				emit     = wneg;
				emit_adv = wneg;
			end
			tdr_pkg::ST_Z4: begin
				emit     = 1'b1;
				emit_adv = 1'b1;
				e_z      = z_next;
				e_wc     = wc_q;
				if (z_next > $signed(mem_rdata)) begin
					mem_we = 1'b1;
					e_stat = tdr_pkg::STAT_WRITTEN;
				end else begin
					e_stat = tdr_pkg::STAT_REJECT;
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tdr_pkg::ST_CLR;
			clr_q    <= '0;
			active_q <= 1'b0;
			out_v_q  <= 1'b0;
			vi_q     <= '0;
			vc_q     <= '0;
			vw_q     <= 9'd256;
			vh_q     <= 9'd256;
			vx_q     <= '0;
			vy_q     <= '0;
			sx_q     <= '0;
			sy_q     <= '0;
		end else begin
			state_q <= state_d;
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					tdr_pkg::REG_VIEW_WIDTH:  vw_q <= cfg_wdata[8:0];
					tdr_pkg::REG_VIEW_HEIGHT: vh_q <= cfg_wdata[8:0];
					tdr_pkg::REG_VIEW_X:      vx_q <= $signed(cfg_wdata);
					tdr_pkg::REG_VIEW_Y:      vy_q <= $signed(cfg_wdata);
					default: ;
				endcase
			end
			// clearing sweep
			if (state_q == tdr_pkg::ST_CLR) begin
				clr_q <= clr_last ? '0 : clr_q + 1'b1;
			end
			// setup sequencing over vertices and coordinates
			if (state_q == tdr_pkg::ST_CHK) begin
				vi_q <= '0;
				vc_q <= '0;
				if (w_bad) active_q <= 1'b0;
			end
			if ((state_q == tdr_pkg::ST_VWAIT && div_done && vc_q == 2'd2) ||
					state_q == tdr_pkg::ST_SADD) begin
				if (vc_q == 2'd2) begin
					vc_q <= '0;
					vi_q <= vi_q + 1'b1;
				end else begin
					vc_q <= vc_q + 1'b1;
				end
			end
			if (state_q == tdr_pkg::ST_AR3) begin
				active_q <= 1'b1;
				sx_q     <= bx0_q;
				sy_q     <= by0_q;
			end
			// scan advance after a reported pixel
			if (emit_adv) begin
				if (is_last) begin
					active_q <= 1'b0;
				end else if (sx_q >= bx1_q) begin
					sx_q <= bx0_q;
					sy_q <= sy_q + 1'b1;
				end else begin
					sx_q <= sx_q + 1'b1;
				end
			end
			// output register
			if (m_tready) out_v_q <= 1'b0;
			if (emit) out_v_q <= 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		// vertex capture
		if (acc_in && in_mode == tdr_pkg::MODE_LOAD) begin
			for (int i = 0; i < 3; i++) begin
				if (in_slot == 2'(i)) begin
					xyz_q[i*3]     <= $signed(s_tdata[33:2]);
					xyz_q[i*3 + 1] <= $signed(s_tdata[65:34]);
					xyz_q[i*3 + 2] <= $signed(s_tdata[97:66]);
					w_q[i]         <= $signed(s_tdata[129:98]);
				end
			end
		end
		// perspective divide results
		if (state_q == tdr_pkg::ST_VWAIT && div_done) begin
			if (vc_q == 2'd2) begin
				nz_q[vi_q] <= q_sat;
			end else begin
				n_q <= q_sat;
			end
		end
		if (state_q == tdr_pkg::ST_SMUL) begin
			sp_q <= n_q * $signed({1'b0, (vc_q == 2'd0) ? vw_q : vh_q});
		end
		if (state_q == tdr_pkg::ST_SADD) begin
			scr_q[3'(vi_q) * 3'd2 + 3'(vc_q)] <= s_sat;
		end
		// bounding box clamped to the frame
		if (state_q == tdr_pkg::ST_BOX) begin
			bx0_q <= CW'(clamp(32'(xmin) >>> 16, FRAME_WIDTH - 1));
			bx1_q <= CW'(clamp((32'(xmax) + 32'sd65535) >>> 16, FRAME_WIDTH - 1));
			by0_q <= RW'(clamp(32'(ymin) >>> 16, FRAME_HEIGHT - 1));
			by1_q <= RW'(clamp((32'(ymax) + 32'sd65535) >>> 16, FRAME_HEIGHT - 1));
		end
		// shared edge multiplier
		mp_q <= ea * eb;
		if (state_q == tdr_pkg::ST_AR2 || state_q == tdr_pkg::ST_E2 ||
				state_q == tdr_pkg::ST_E4) begin
			ma_q <= mp_q;
		end
		if (state_q == tdr_pkg::ST_AR3) begin
			area_q  <= 49'(ma_q) - 49'(mp_q);
			degen_q <= ma_q == mp_q;
		end
		if (state_q == tdr_pkg::ST_E3 || state_q == tdr_pkg::ST_E5) begin
			pbc_q <= 49'(ma_q) - 49'(mp_q);
		end
		// weight divides
		if (state_q == tdr_pkg::ST_WAW && div_done) wa_q <= q_sat;
		if (state_q == tdr_pkg::ST_WBW && div_done) wb_q <= q_sat;
		if (state_q == tdr_pkg::ST_WC) wc_q <= wc_next;
		// depth multiply-accumulate
		case (state_q)
			tdr_pkg::ST_Z0: zp_q <= nz_q[0] * wa_q;
			tdr_pkg::ST_Z1: begin
				acc_q <= 66'(zp_q);
				zp_q  <= nz_q[1] * wb_q;
			end
			tdr_pkg::ST_Z2: begin
				acc_q <= acc_q + 66'(zp_q);
				zp_q  <= nz_q[2] * wc_q;
			end
			tdr_pkg::ST_Z3: acc_q <= acc_q + 66'(zp_q);
			default: ;
		endcase
		// result capture
		if (emit) begin
			out_stat_q <= e_stat;
			out_last_q <= e_last;
			out_data_q <= {e_wc, e_wb, e_wa, e_z, e_y, e_x};
		end
	end

	tdr_div #(.W(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	tdr_zbuf #(.DEPTH(DEPTH), .AW(AW)) u_zbuf (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (pix_addr),
		.rdata (mem_rdata)
	);

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_stat_q;
	assign m_tlast  = out_last_q;
endmodule
`default_nettype wire

// File: rtl/tdr_checker.sv
// port-level checks of the rasterizer result stream
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_depth_rasterizer_unit_assert.svh"
module tdr_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [143:0] m_tdata,
	input wire logic [1:0]   m_tuser,
	input wire logic         m_tlast
);
	// a stalled result stays offered
	`TDR_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped")
	// no active triangle ends the run
	`TDR_ASSERT_NOW(a_idle_last, clk, arst_n, m_tvalid && m_tuser == tdr_pkg::STAT_IDLE, m_tlast, "idle result without last")
	// no active triangle reports all zero fields
	`TDR_ASSERT_NOW(a_idle_zero, clk, arst_n, m_tvalid && m_tuser == tdr_pkg::STAT_IDLE, m_tdata == '0, "idle result with data")
	// a written pixel has nonnegative weights
	`TDR_ASSERT_NOW(a_wr_wts, clk, arst_n, m_tvalid && m_tuser == tdr_pkg::STAT_WRITTEN, !m_tdata[79] && !m_tdata[111] && !m_tdata[143], "written pixel outside")
endmodule

bind triangle_depth_rasterizer_unit tdr_checker u_tdr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire

// File: tb/sv/tb_triangle_depth_rasterizer_unit.sv
// self-checking testbench of the triangle depth rasterizer: directed table, then random triangles
`timescale 1ns / 1ps
module tb_triangle_depth_rasterizer_unit;
	import tdr_pkg::*;

	typedef struct {
		logic [1:0]         mode;
		logic [1:0]         slot;
		logic signed [31:0] cx, cy, cz, cw;
	} vin_t;

	typedef struct {
		logic [7:0]  px, py;
		logic [1:0]  st;
		logic [31:0] dep, wa, wb, wc;
		logic        lst;
	} pix_t;

	// directed row: item, repeat count, typed expectation where obvious
	typedef struct {
		vin_t item;
		int   reps;
		bit   typed;
		pix_t res;
	} row_t;

	localparam logic signed [31:0] Q1 = 32'sh0001_0000;
	localparam int DRAIN_CYCLES = 800;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [143:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [9:0]   cfg_wdata;

	triangle_depth_rasterizer_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// shadow state of the rasterizer
	longint vtx[12];
	longint scr[6];
	longint ndcz[3];
	longint area2;
	bit     degen;
	longint bnd[4];
	longint scan_x, scan_y;
	bit     busy_tri;
	int     zbuf[65536];
	longint vw, vh, vx, vy;

	pix_t   pixel_q[$];
	int     errors;
	int     item_count;
	int     burst_left;
	bit     ready_free;
	int     ready_left;

	function automatic longint floor_div(longint v, longint d);
		longint q;
		q = v / d;
		if (v % d != 0 && v < 0) q--;
		return q;
	endfunction

	function automatic longint clampl(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint s32(longint v);
		return clampl(v, -64'sd2147483648, 64'sd2147483647);
	endfunction

	function automatic longint min3(longint a, longint b, longint c);
		longint m;
		m = a < b ? a : b;
		return m < c ? m : c;
	endfunction

	function automatic longint max3(longint a, longint b, longint c);
		longint m;
		m = a > b ? a : b;
		return m > c ? m : c;
	endfunction

	function automatic void clear_zbuf();
		for (int i = 0; i < 65536; i++) zbuf[i] = -65536000;
	endfunction

	// perspective divide, viewport, box and doubled area
	function automatic void triangle_setup();
		longint w, nx, ny, lim;
		lim = 64'sd134217728;
		for (int i = 0; i < 3; i++) begin
			if (vtx[i*4+3] <= 0) begin
				busy_tri = 0;
				return;
			end
		end
		for (int i = 0; i < 3; i++) begin
			w = vtx[i*4+3];
			nx = s32(vtx[i*4] * 65536 / w);
			ny = s32(vtx[i*4+1] * 65536 / w);
			ndcz[i] = s32(vtx[i*4+2] * 65536 / w);
			scr[i*2] = clampl(floor_div(nx*vw + vx*131072 + vw*65536, 2), -lim, lim-1);
			scr[i*2+1] = clampl(floor_div(ny*vh + vy*131072 + vh*65536, 2), -lim, lim-1);
		end
		bnd[0] = clampl(floor_div(min3(scr[0], scr[2], scr[4]), 65536), 0, 255);
		bnd[1] = clampl(-floor_div(-max3(scr[0], scr[2], scr[4]), 65536), 0, 255);
		bnd[2] = clampl(floor_div(min3(scr[1], scr[3], scr[5]), 65536), 0, 255);
		bnd[3] = clampl(-floor_div(-max3(scr[1], scr[3], scr[5]), 65536), 0, 255);
		begin
			longint ax, ay, bx, by, qx, qy;
			ax = floor_div(scr[0], 256); ay = floor_div(scr[1], 256);
			bx = floor_div(scr[2], 256); by = floor_div(scr[3], 256);
			qx = floor_div(scr[4], 256); qy = floor_div(scr[5], 256);
			area2 = (bx - ax) * (qy - ay) - (qx - ax) * (by - ay);
		end
		degen = (area2 == 0);
		scan_x = bnd[0];
		scan_y = bnd[2];
		busy_tri = 1;
	endfunction

	// one pixel of the scan: weights, depth test, advance
	function automatic pix_t visit_pixel();
		pix_t r;
		longint x, y, wa, wb, wc, z, st, ax, ay, bx, by, qx, qy, px, py, pbc, pca;
		bit lst;
		r = '{default: '0};
		if (!busy_tri) begin
			r.st = STAT_IDLE;
			r.lst = 1'b1;
			return r;
		end
		x = scan_x;
		y = scan_y;
		z = 0;
		lst = (x == bnd[1] && y == bnd[3]);
		if (degen) begin
			wa = -65536; wb = 65536; wc = 65536;
			st = STAT_OUTSIDE;
		end else begin
			ax = floor_div(scr[0], 256); ay = floor_div(scr[1], 256);
			bx = floor_div(scr[2], 256); by = floor_div(scr[3], 256);
			qx = floor_div(scr[4], 256); qy = floor_div(scr[5], 256);
			px = x * 256; py = y * 256;
			pbc = (bx - px) * (qy - py) - (qx - px) * (by - py);
			pca = (qx - px) * (ay - py) - (ax - px) * (qy - py);
			wa = s32(pbc * 65536 / area2);
			wb = s32(pca * 65536 / area2);
			wc = s32(65536 - wa - wb);
			if (wa < 0 || wb < 0 || wc < 0) begin
				st = STAT_OUTSIDE;
			end else begin
				z = s32(floor_div(ndcz[0]*wa + ndcz[1]*wb + ndcz[2]*wc, 65536));
				if (z > zbuf[x + y*256]) begin
					zbuf[x + y*256] = int'(z);
					st = STAT_WRITTEN;
				end else begin
					st = STAT_REJECT;
				end
			end
		end
		if (lst) begin
			busy_tri = 0;
		end else if (scan_x >= bnd[1]) begin
			scan_x = bnd[0];
			scan_y++;
		end else begin
			scan_x++;
		end
		r.px = x[7:0]; r.py = y[7:0]; r.st = st[1:0];
		r.dep = z[31:0]; r.wa = wa[31:0]; r.wb = wb[31:0]; r.wc = wc[31:0];
		r.lst = lst;
		return r;
	endfunction

	// apply one accepted item, returns 1 when it gives a pixel
	function automatic bit predict_item(vin_t it, output pix_t r);
		r = '{default: '0};
		if (it.mode == MODE_LOAD) begin
			if (it.slot != 2'd3) begin
				vtx[it.slot*4]   = it.cx;
				vtx[it.slot*4+1] = it.cy;
				vtx[it.slot*4+2] = it.cz;
				vtx[it.slot*4+3] = it.cw;
				if (it.slot == 2'd2) triangle_setup();
			end
			return 0;
		end
		if (it.mode == MODE_CLEAR) begin
			clear_zbuf();
			return 0;
		end
		if (it.mode == MODE_STEP) begin
			r = visit_pixel();
			return 1;
		end
		return 0;
	endfunction

	function automatic vin_t mk(logic [1:0] m, logic [1:0] s, int x, int y, int z, int w);
		vin_t it;
		it.mode = m; it.slot = s; it.cx = x; it.cy = y; it.cz = z; it.cw = w;
		return it;
	endfunction

	// sender pacing: bursts of random length with random gaps
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 10);
		end
	endtask

	// drive one item, wait for its transfer, then predict it
	task automatic send(vin_t it, bit typed = 0, pix_t tres = '{default: '0});
		pix_t r;
		bit has;
		s_tvalid <= 1'b1;
		s_tuser  <= it.mode;
		s_tdata  <= {6'b0, it.cw, it.cz, it.cy, it.cx, it.slot};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		has = predict_item(it, r);
		if (has) pixel_q.push_back(typed ? tres : r);
		if (!(it.mode == 2'd3 || (it.mode == MODE_LOAD && it.slot == 2'd3))) item_count++;
		pace();
	endtask

	// sender pauses until the block is idle again
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic set_view(int w, int h, int x, int y);
		logic [9:0] v[4];
		v[0] = w[9:0]; v[1] = h[9:0]; v[2] = x[9:0]; v[3] = y[9:0];
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= i[1:0];
			cfg_wdata <= v[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		vw = w[8:0];
		vh = h[8:0];
		vx = longint'($signed(v[2]));
		vy = longint'($signed(v[3]));
	endtask

	function automatic int rnd_coord(int span);
		return int'($urandom_range(0, 2*span)) - span;
	endfunction

	// random vertex: mostly plain w, sometimes scaled, a few culling
	function automatic vin_t rnd_vertex(logic [1:0] s, int span);
		int w, z, p;
		p = $urandom_range(0, 99);
		if (p < 75) w = Q1;
		else if (p < 95) w = $urandom_range(32'h4000, 32'h30000);
		else w = -int'($urandom_range(0, 65536));
		z = ($urandom_range(0, 1) == 0) ? rnd_coord(65536) : int'($urandom);
		return mk(MODE_LOAD, s, rnd_coord(span), rnd_coord(span), z, w);
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#50_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// receiver stalls: free-running stretches and random stretches
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_free <= ($urandom_range(0, 2) == 0);
			ready_left <= $urandom_range(5, 60);
		end else begin
			ready_left <= ready_left - 1;
		end
		m_tready <= ready_free ? 1'b1 : ($urandom_range(0, 2) != 0);
	end

	// result check against the oldest expected pixel
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			pix_t e, a;
			a.px = m_tdata[7:0]; a.py = m_tdata[15:8]; a.dep = m_tdata[47:16];
			a.wa = m_tdata[79:48]; a.wb = m_tdata[111:80]; a.wc = m_tdata[143:112];
			a.st = m_tuser; a.lst = m_tlast;
			if (pixel_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected pixel transfer x=%0d y=%0d", a.px, a.py);
			end else begin
				e = pixel_q.pop_front();
				if (e != a) begin
					errors++;
					if (errors <= 10)
						$display("pixel mismatch exp x=%0d y=%0d st=%0d z=%h w=%h/%h/%h l=%0d got x=%0d y=%0d st=%0d z=%h w=%h/%h/%h l=%0d",
							e.px, e.py, e.st, e.dep, e.wa, e.wb, e.wc, e.lst,
							a.px, a.py, a.st, a.dep, a.wa, a.wb, a.wc, a.lst);
				end
			end
		end
	end

	// stimulus
	initial begin
		row_t rows[$];
		pix_t idle_px;
		int views[5][4];
		int target, span, k, r;

		arst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tuser = MODE_LOAD;
		cfg_we = 1'b0; cfg_index = REG_VIEW_WIDTH; cfg_wdata = '0;
		m_tready = 1'b0; ready_free = 1'b1; ready_left = 0;
		errors = 0; item_count = 0; burst_left = 0;
		foreach (vtx[i]) vtx[i] = 0;
		foreach (scr[i]) scr[i] = 0;
		foreach (ndcz[i]) ndcz[i] = 0;
		foreach (bnd[i]) bnd[i] = 0;
		area2 = 0; degen = 0; scan_x = 0; scan_y = 0; busy_tri = 0;
		vw = 256; vh = 256; vx = 0; vy = 0;
		clear_zbuf();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);

		idle_px = '{default: '0};
		idle_px.st = STAT_IDLE;
		idle_px.lst = 1'b1;

		// directed table
		rows.push_back('{mk(MODE_STEP, 0, 0, 0, 0, 0), 1, 1, idle_px});
		rows.push_back('{mk(2'd3, 0, 0, 0, 0, 0), 1, 0, idle_px});
		rows.push_back('{mk(MODE_LOAD, 2'd3, -1, -1, -1, -1), 1, 0, idle_px});
		rows.push_back('{mk(MODE_LOAD, 0, -1311, -1311, 0, Q1), 1, 0, idle_px});
		rows.push_back('{mk(MODE_LOAD, 1, 1311, -1311, 6554, Q1), 1, 0, idle_px});
		rows.push_back('{mk(MODE_LOAD, 2, 0, 1311, -6554, Q1), 1, 0, idle_px});
		rows.push_back('{mk(MODE_STEP, 0, 0, 0, 0, 0), 40, 0, idle_px});
		rows.push_back('{mk(MODE_LOAD, 2, 0, 1311, 0, 0), 1, 0, idle_px});
		rows.push_back('{mk(MODE_STEP, 0, 0, 0, 0, 0), 1, 1, idle_px});
		rows.push_back('{mk(MODE_LOAD, 2, 0, 1311, 0, 32'sh8000_0000), 1, 0, idle_px});
		rows.push_back('{mk(MODE_STEP, 0, 0, 0, 0, 0), 1, 1, idle_px});
		rows.push_back('{mk(MODE_LOAD, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF), 1, 0, idle_px});
		rows.push_back('{mk(MODE_LOAD, 1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1),
			1, 0, idle_px});
		rows.push_back('{mk(MODE_LOAD, 2, 0, 32'sh7FFF_FFFF, 0, Q1), 1, 0, idle_px});
		rows.push_back('{mk(MODE_STEP, 0, 0, 0, 0, 0), 4, 0, idle_px});
		rows.push_back('{mk(MODE_LOAD, 0, 655, 655, 0, Q1), 1, 0, idle_px});
		rows.push_back('{mk(MODE_LOAD, 1, 655, 655, 0, Q1), 1, 0, idle_px});
		rows.push_back('{mk(MODE_LOAD, 2, 655, 655, 0, Q1), 1, 0, idle_px});
		rows.push_back('{mk(MODE_STEP, 0, 0, 0, 0, 0), 3, 0, idle_px});
		rows.push_back('{mk(MODE_LOAD, 0, -1311, -1311, 0, Q1), 1, 0, idle_px});
		rows.push_back('{mk(MODE_LOAD, 1, 1311, -1311, 6554, Q1), 1, 0, idle_px});
		rows.push_back('{mk(MODE_LOAD, 2, 0, 1311, -6554, Q1), 1, 0, idle_px});
		rows.push_back('{mk(MODE_STEP, 0, 0, 0, 0, 0), 40, 0, idle_px});
		rows.push_back('{mk(MODE_CLEAR, 0, 0, 0, 0, 0), 1, 0, idle_px});
		rows.push_back('{mk(MODE_LOAD, 2, 0, 1311, -6554, Q1), 1, 0, idle_px});
		rows.push_back('{mk(MODE_STEP, 0, 0, 0, 0, 0), 8, 0, idle_px});
		foreach (rows[i]) begin
			for (int j = 0; j < rows[i].reps; j++) send(rows[i].item, rows[i].typed, rows[i].res);
		end
		drain();

		// viewport settings, extremes among them
		views = '{'{256, 256, 0, 0}, '{1, 1, -256, -256}, '{8, 8, 100, 50},
			'{256, 256, 256, 256}, '{37, 200, -20, 3}};
		target = item_count;
		for (int ph = 0; ph < 5; ph++) begin
			set_view(views[ph][0], views[ph][1], views[ph][2], views[ph][3]);
			target += 370;
			if (ph == 2) send(mk(MODE_CLEAR, 0, 0, 0, 0, 0));
			while (item_count < target) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					// random triangle, mostly well formed, then part of its scan
					k = $urandom_range(0, 3);
					span = (k == 0) ? 1311 : (k == 1) ? 6554 : (k == 2) ? 19661 : 98304;
					for (int s = 0; s < 3; s++) send(rnd_vertex(s[1:0], span));
					k = $urandom_range(1, 40);
					for (int j = 0; j < k; j++) begin
						if ($urandom_range(0, 19) == 0)
							send(rnd_vertex($urandom_range(0, 1), span));
						send(mk(MODE_STEP, 0, 0, 0, 0, 0));
					end
				end else if (r < 85) begin
					// noise with full-range fields
					vin_t it;
					it = mk($urandom_range(0, 3), $urandom_range(0, 3), $urandom, $urandom,
						$urandom, $urandom);
					if (it.mode == MODE_CLEAR) it.mode = MODE_STEP;
					send(it);
				end else begin
					k = $urandom_range(1, 5);
					for (int j = 0; j < k; j++) send(mk(MODE_STEP, 0, 0, 0, 0, 0));
				end
				if (item_count >= target - 185 && item_count < target - 170) drain();
			end
			drain();
		end

		s_tvalid <= 1'b0;
		if (errors == 0 && pixel_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
